[src/ffba_pkg.sv]
// Shared types, codes and defaults for the first-fit block allocator.
package ffba_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF  = 24;

  localparam int REQ_W  = 24;
  localparam int ADDR_W = 32;
  localparam int LIM_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN    = 2'd2;
  localparam logic [1:0] ST_TABLE_FULL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 2'd1;

  localparam logic [LIM_W-1:0] HEAP_LIMIT_RST = 24'hFF_FFFF;

  // Search probe handed from cell to cell
  typedef struct packed {
    logic              active;
    logic              func;
    logic              hit;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] target;
  } probe_t;

endpackage

[src/ffba_cell.sv]
// One table entry of the allocator: holds a block and checks the passing probe.
module ffba_cell import ffba_pkg::*; #(
  parameter int MaxBlocks  = MAX_BLOCKS_DEF,
  parameter int OffsetBits = OFFSET_BITS_DEF,
  parameter int Index      = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [$clog2(MaxBlocks+1)-1:0]   count,
  input  logic                             wr_en,
  input  logic [$clog2(MaxBlocks)-1:0]     wr_idx,
  input  logic [OffsetBits-1:0]            wr_offset,
  input  logic [REQ_W-1:0]                 wr_size,
  input  probe_t                           probe_in,
  input  logic [OffsetBits-1:0]            hit_off_in,
  output probe_t                           probe_out,
  output logic [OffsetBits-1:0]            hit_off_out
);

  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = $clog2(MaxBlocks + 1);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);
  localparam logic [CntW-1:0] MyCnt = CntW'(Index);

  logic [OffsetBits-1:0] offset;
  logic [REQ_W-1:0]      size;
  logic                  free;
  logic                  in_range;
  logic                  fits;
  logic                  match;
  probe_t                probe_next;

  assign in_range = MyCnt < count;
  assign fits = (probe_in.func == FUNC_ALLOC) ? (free && (size >= probe_in.req))
                                              : (ADDR_W'(offset) == probe_in.target);
  assign match = probe_in.active && !probe_in.hit && in_range && fits;

  always_comb begin
    probe_next     = probe_in;
    probe_next.hit = probe_in.hit | match;
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MyIdx)) begin
      offset <= wr_offset;
      size   <= wr_size;
      free   <= 1'b0;
    end else if (match) begin
      free <= (probe_in.func == FUNC_FREE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

  always_ff @(posedge clk) begin
    hit_off_out <= match ? offset : hit_off_in;
  end

endmodule

[src/first_fit_block_allocator.sv]
// First-fit heap block allocator built as a chain of table cells.
// A request (allocate or free) is taken when start is high and busy is low. The probe then
// walks the cell chain one entry per cycle, after the launch register, and the result is
// registered onto status and payload_addr with done high for one cycle; it is taken at the
// edge that ends that cycle. busy drops together with done, so the next request can be
// issued in the done cycle, but no new request is taken while one is still in the chain.
// Results cannot be held off; the receiver must take done.
// Allocate takes the first free block whose size fits, else appends a block at the heap
// end while the table has an entry left and the new end stays within the heap limit.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int MaxBlocks   = MAX_BLOCKS_DEF,
  parameter int HeaderBytes = HEADER_BYTES_DEF,
  parameter int OffsetBits  = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func,
  input  logic [REQ_W-1:0]     req_size,
  input  logic [ADDR_W-1:0]    block_addr,
  output logic                 done,
  output logic [1:0]           status,
  output logic [ADDR_W-1:0]    payload_addr,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = $clog2(MaxBlocks + 1);
  localparam int SumW = ((OffsetBits > REQ_W) ? OffsetBits : REQ_W) + 2;
  localparam logic [SumW-1:0] OfsMax = SumW'((64'(1) << OffsetBits) - 64'(1));
  localparam logic [CntW-1:0] CntFull = CntW'(MaxBlocks);

  logic [ADDR_W-1:0]     heap_base;
  logic [LIM_W-1:0]      heap_limit;
  logic [CntW-1:0]       count;
  logic [OffsetBits-1:0] end_offset;

  probe_t                probe  [MaxBlocks+1];
  logic [OffsetBits-1:0] hit_off[MaxBlocks+1];
  probe_t                launch;

  logic                  accept;
  probe_t                tail;
  logic [SumW-1:0]       new_end;
  logic [SumW-1:0]       lim;
  logic                  wr_en;
  logic [1:0]            status_next;
  logic [ADDR_W-1:0]     payload_next;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_limit <= HEAP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEAP_BASE:  heap_base  <= cfg_data;
        REG_HEAP_LIMIT: heap_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Launch the probe; a free looks for the offset whose payload address matches
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= '0;
    end else begin
      launch <= '{active: accept, func: func, hit: 1'b0, req: req_size,
                  target: block_addr - heap_base - ADDR_W'(HeaderBytes)};
    end
  end

  assign probe[0]   = launch;
  assign hit_off[0] = '0;

  for (genvar i = 0; i < MaxBlocks; i++) begin : g_cell
    ffba_cell #(
      .MaxBlocks (MaxBlocks),
      .OffsetBits(OffsetBits),
      .Index     (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .count      (count),
      .wr_en      (wr_en),
      .wr_idx     (count[IdxW-1:0]),
      .wr_offset  (end_offset),
      .wr_size    (tail.req),
      .probe_in   (probe[i]),
      .hit_off_in (hit_off[i]),
      .probe_out  (probe[i+1]),
      .hit_off_out(hit_off[i+1])
    );
  end

  assign tail = probe[MaxBlocks];

  // Resolve the probe at the end of the chain
  always_comb begin
    new_end = SumW'(end_offset) + SumW'(HeaderBytes) + SumW'(tail.req);
    lim     = (SumW'(heap_limit) > OfsMax) ? OfsMax : SumW'(heap_limit);
    wr_en        = 1'b0;
    status_next  = ST_OK;
    payload_next = '0;
    if (tail.hit) begin
      if (tail.func == FUNC_ALLOC) begin
        payload_next = heap_base + ADDR_W'(hit_off[MaxBlocks]) + ADDR_W'(HeaderBytes);
      end
    end else if (tail.func == FUNC_FREE) begin
      status_next = ST_UNKNOWN;
    end else if (count == CntFull) begin
      status_next = ST_TABLE_FULL;
    end else if (new_end > lim) begin
      status_next = ST_NO_SPACE;
    end else begin
      wr_en        = tail.active;
      payload_next = heap_base + ADDR_W'(end_offset) + ADDR_W'(HeaderBytes);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      count      <= '0;
      end_offset <= '0;
    end else begin
      done <= tail.active;
      if (accept) begin
        busy <= 1'b1;
      end else if (tail.active) begin
        busy <= 1'b0;
      end
      if (wr_en) begin
        count      <= count + CntW'(1);
        end_offset <= new_end[OffsetBits-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.active) begin
      status       <= status_next;
      payload_addr <= payload_next;
    end
  end

endmodule

[src/ffba_checker.sv]
// Port-level checks for the allocator, bound to the top level.
module ffba_checker import ffba_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [1:0]        status,
  input logic [ADDR_W-1:0] payload_addr
);

  // A result closes the request: busy is already low when it shows
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // Failed requests report address zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (payload_addr == '0))
    else $error("nonzero payload address on a failed request");

  // An issued request occupies the block
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but busy not raised");

  // Results never come in back-to-back cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
